// ----- rtl/mlq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlq_pkg
// Shared sizes, operation codes, status codes and budget reset values for
// the multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);

  localparam int OP_W     = 2;
  localparam int PID_W    = 8;
  localparam int LEVEL_W  = 3;
  localparam int USED_W   = 8;
  localparam int STATUS_W = 2;
  localparam int BUDGET_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SELECT = 2'd1,
    OP_CHARGE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef logic signed [BUDGET_W-1:0] budget_t;

  function automatic budget_t budget_init(input int idx);
    budget_init = BUDGET_W'(NUM_LEVELS - idx);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mlq_slot_budget_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlq_slot_budget_scheduler
// Multilevel ready-queue scheduler with one id FIFO and one signed slot
// budget per priority level.
//
// Input channel (in_valid / in_stall) carries opcode, process_id, level and
// slice_used. Output channel (out_valid / out_stall) carries one result per
// input item: granted, grant_id, grant_level, status, budget_left, any_ready.
// An item is taken when valid is high and stall is low.
//
// Each item passes through the EXEC state, for the level scan and the update of
// the per-level pointers, counts and budgets together with the access to
// the id memory, and then the DONE state, for the registered read data of
// that memory, from which the result is loaded into the output register.
// The next item is taken in the same cycle the result is loaded, so the
// block takes no new item until the last one is through its DONE state.
// A stalled result holds in the output register; the block then holds
// in_stall high until the result can move.
// Reset empties every queue and sets each budget to the level count minus
// the level index; the id memory needs no clearing pass.
// ----------------------------------------------------------------------------
module mlq_slot_budget_scheduler
  import mlq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [OP_W-1:0]            opcode,
  input  wire logic [PID_W-1:0]           process_id,
  input  wire logic [LEVEL_W-1:0]         level,
  input  wire logic [USED_W-1:0]          slice_used,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            granted,
  output logic [PID_W-1:0]                grant_id,
  output logic [LEVEL_W-1:0]              grant_level,
  output logic [STATUS_W-1:0]             status,
  output logic signed [BUDGET_W-1:0]      budget_left,
  output logic                            any_ready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [OP_W-1:0]    item_op;
  logic [PID_W-1:0]   item_pid;
  logic [LEVEL_W-1:0] item_level;
  logic [USED_W-1:0]  item_used;

  logic [PTR_W-1:0] head  [NUM_LEVELS];
  logic [PTR_W-1:0] tail  [NUM_LEVELS];
  logic [CNT_W-1:0] count [NUM_LEVELS];
  budget_t          budget [NUM_LEVELS];

  logic [PID_W-1:0] queue_mem [NUM_LEVELS * QUEUE_DEPTH];
  logic [PID_W-1:0] mem_rdata;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  logic                res_granted;
  logic [LEVEL_W-1:0]  res_level;
  status_t             res_status;
  budget_t             res_budget;

  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] cand;
  logic                  any_nonempty;
  logic                  found_cand;
  logic [LVL_W-1:0]      pick_cand;
  logic [LVL_W-1:0]      pick_any;
  logic [LVL_W-1:0]      pick;
  logic                  lvl_ok;
  logic [LVL_W-1:0]      lvl_idx;
  logic                  full;
  logic signed [BUDGET_W:0] diff;
  budget_t               charged;
  logic                  out_free;
  logic                  take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) || ((state == S_DONE) && out_free));
  assign take     = in_valid && !in_stall;

  always_comb begin
    nonempty   = '0;
    cand       = '0;
    found_cand = 1'b0;
    pick_cand  = '0;
    pick_any   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      nonempty[i] = (count[i] != '0);
      cand[i]     = nonempty[i] && (budget[i] > 0);
      if (cand[i]) begin
        found_cand = 1'b1;
        pick_cand  = LVL_W'(i);
      end
      if (nonempty[i]) begin
        pick_any = LVL_W'(i);
      end
    end
    any_nonempty = |nonempty;
    pick         = found_cand ? pick_cand : pick_any;
    lvl_ok       = int'(item_level) < NUM_LEVELS;
    lvl_idx      = LVL_W'(item_level);
    full         = count[lvl_idx] >= CNT_W'(QUEUE_DEPTH);
    diff         = {budget[lvl_idx][BUDGET_W-1], budget[lvl_idx]}
                   - {{(BUDGET_W + 1 - USED_W){1'b0}}, item_used};
    charged      = (diff[BUDGET_W] != diff[BUDGET_W-1])
                   ? {1'b1, {(BUDGET_W - 1){1'b0}}} : diff[BUDGET_W-1:0];
    mem_we       = (state == S_EXEC) && (item_op == OP_ADD) && lvl_ok && !full;
    mem_re       = (state == S_EXEC) && (item_op == OP_SELECT);
    mem_waddr    = ADDR_W'(int'(lvl_idx) * QUEUE_DEPTH + int'(tail[lvl_idx]));
    mem_raddr    = ADDR_W'(int'(pick) * QUEUE_DEPTH + int'(head[pick]));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[mem_waddr] <= item_pid;
    end
    if (mem_re) begin
      mem_rdata <= queue_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_op    <= opcode;
      item_pid   <= process_id;
      item_level <= level;
      item_used  <= slice_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]   <= '0;
        tail[i]   <= '0;
        count[i]  <= '0;
        budget[i] <= budget_init(i);
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_granted <= 1'b0;
          res_level   <= '0;
          res_status  <= ST_OK;
          res_budget  <= '0;
          case (item_op)
            OP_ADD: begin
              if (!lvl_ok || full) begin
                res_status <= ST_DROPPED;
              end else begin
                tail[lvl_idx]  <= (tail[lvl_idx] == PTR_W'(QUEUE_DEPTH - 1))
                                  ? '0 : tail[lvl_idx] + 1'b1;
                count[lvl_idx] <= count[lvl_idx] + 1'b1;
              end
              if (lvl_ok) begin
                res_budget <= budget[lvl_idx];
              end
            end
            OP_SELECT: begin
              if (!any_nonempty) begin
                res_status <= ST_NONE;
              end else begin
                if (!found_cand) begin
                  for (int i = 0; i < NUM_LEVELS; i++) begin
                    budget[i] <= budget_init(i);
                  end
                end
                head[pick]  <= (head[pick] == PTR_W'(QUEUE_DEPTH - 1))
                               ? '0 : head[pick] + 1'b1;
                count[pick] <= count[pick] - 1'b1;
                res_granted <= 1'b1;
                res_level   <= LEVEL_W'(pick);
                res_budget  <= found_cand ? budget[pick] : budget_init(int'(pick));
              end
            end
            OP_CHARGE: begin
              if (lvl_ok) begin
                budget[lvl_idx] <= charged;
                res_budget      <= charged;
              end
            end
            default: begin
              if (lvl_ok) begin
                res_budget <= budget[lvl_idx];
              end
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= take ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      granted     <= res_granted;
      grant_id    <= res_granted ? mem_rdata : '0;
      grant_level <= res_level;
      status      <= res_status;
      budget_left <= res_budget;
      any_ready   <= any_nonempty;
    end
  end

endmodule
`default_nettype wire
